>>> hw/rtl/symmetric_fir_row_filter_unit_assert.svh
// Assertion shorthands for the checker file of the row filter.
`ifndef SYMMETRIC_FIR_ROW_FILTER_UNIT_ASSERT_SVH
`define SYMMETRIC_FIR_ROW_FILTER_UNIT_ASSERT_SVH

// Condition that must hold in the same cycle as the trigger.
`define SFIR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("row filter check failed");

// Condition that must hold in the cycle after the trigger.
`define SFIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("row filter check failed");

`endif

>>> hw/rtl/sfir_pkg.sv
package sfir_pkg;

  localparam int MAX_HALF_LENGTH_DEF = 5;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int ROW_W       = 16;
  localparam int LEN_W       = 3;
  localparam int WEIGHT_W    = 16;
  localparam int NUM_WEIGHTS = 6;
  localparam int ROUND_SHIFT = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0    = 3'd2;

  localparam logic [ROW_W-1:0]           ROW_WIDTH_RST   = 16'd1024;
  localparam logic [LEN_W-1:0]           HALF_LENGTH_RST = 3'd2;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_0_RST    = 16'sd32767;

endpackage

>>> hw/rtl/sfir_mac.sv
module sfir_mac #(
  parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF,
  parameter int NUM_LANES   = sfir_pkg::NUM_WEIGHTS
) (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic signed [SAMPLE_BITS-1:0]          center,
  input  logic signed [SAMPLE_BITS:0]            pair [NUM_LANES-1],
  input  logic signed [sfir_pkg::WEIGHT_W-1:0]   weight [NUM_LANES],
  output logic signed [SAMPLE_BITS-1:0]          filt
);

  localparam int P_W        = SAMPLE_BITS + 1 + sfir_pkg::WEIGHT_W;
  localparam int ACC_W      = P_W + $clog2(NUM_LANES) + 1;
  localparam int Q_W        = ACC_W - sfir_pkg::ROUND_SHIFT;
  localparam int ROUND_HALF = 1 << (sfir_pkg::ROUND_SHIFT - 1);

  localparam logic signed [Q_W-1:0] Q_HI = {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_LO = {{(Q_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [P_W-1:0]   prod [NUM_LANES];
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [Q_W-1:0]   q;

  always_ff @(posedge clk) begin
    if (load) begin
      prod[0] <= center * weight[0];
      for (int d = 1; d < NUM_LANES; d++) begin
        prod[d] <= pair[d-1] * weight[d];
      end
    end
  end

  always_comb begin
    acc = ACC_W'(prod[0]);
    for (int d = 1; d < NUM_LANES; d++) begin
      acc = acc + ACC_W'(prod[d]);
    end
  end

  // round half up, then floor shift
  assign rnd = acc + ACC_W'(ROUND_HALF);
  assign q   = rnd[ACC_W-1:sfir_pkg::ROUND_SHIFT];

  always_comb begin
    if (q > Q_HI) begin
      filt = S_HI;
    end else if (q < Q_LO) begin
      filt = S_LO;
    end else begin
      filt = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

>>> hw/rtl/symmetric_fir_row_filter_unit.sv
// Symmetric FIR row filter. Takes one sample per clock on the sample channel while sample_stall
// is low and, for output j of a row, gives the symmetric FIR of half length L when input j+L
// arrives; the first L and the last L+1 outputs of a row are the samples passed through
// unchanged. Each output goes through tap select, symmetric pre-add and a bank of parallel
// multipliers into the product registers, then the sum, round-half-up, shift by 15 and
// saturation into the result register. Ordinary samples are taken back to back while
// result_stall does not back up the pipeline. The last sample of a row releases up to L+1
// results, one per cycle from the same stage unless stalled, so sample_stall stays high until
// the last of them has left it. Results that wait on result_stall do not stop the pipeline from
// filling its empty stages. Write configuration only while no results are pending.
module symmetric_fir_row_filter_unit #(
  parameter int MAX_HALF_LENGTH = sfir_pkg::MAX_HALF_LENGTH_DEF,
  parameter int SAMPLE_BITS     = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [sfir_pkg::CFG_DATA_W-1:0]     write_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       value,
  output logic                                row_end
);

  localparam int DEPTH     = 2 * MAX_HALF_LENGTH + 1;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int LEN_MAX   = (1 << sfir_pkg::LEN_W) - 1;
  localparam int EFF_MAX   = (MAX_HALF_LENGTH < LEN_MAX) ? MAX_HALF_LENGTH : LEN_MAX;
  localparam int NUM_LANES = ((MAX_HALF_LENGTH < sfir_pkg::NUM_WEIGHTS - 1) ?
                              MAX_HALF_LENGTH : sfir_pkg::NUM_WEIGHTS - 1) + 1;
  localparam int W_IDX_W   = $clog2(sfir_pkg::NUM_WEIGHTS);

  // configuration
  logic [sfir_pkg::ROW_W-1:0]            row_width;
  logic [sfir_pkg::LEN_W-1:0]            half_length;
  logic signed [sfir_pkg::WEIGHT_W-1:0]  weight [sfir_pkg::NUM_WEIGHTS];

  // row state
  logic signed [SAMPLE_BITS-1:0]  dl [DEPTH];
  logic [sfir_pkg::ROW_W-1:0]     sample_index;

  // stage 1: item picked at the sample transfer
  logic                       v1;
  logic                       flush1;
  logic                       filt1;
  logic [sfir_pkg::LEN_W-1:0] len1;
  logic [sfir_pkg::LEN_W-1:0] cnt1;

  // stage 2: products and pass value
  logic                          v2;
  logic                          filt2;
  logic                          end2;
  logic signed [SAMPLE_BITS-1:0] pass2;

  // stage 3: result register
  logic v3;

  logic                          ready2;
  logic                          ready3;
  logic                          s1_last;
  logic                          in_xfer;
  logic                          t12;
  logic [sfir_pkg::LEN_W-1:0]    len_c;
  logic [sfir_pkg::ROW_W-1:0]    last_index;
  logic                          at_last;
  logic                          past_len;
  logic                          past_2len;
  logic signed [SAMPLE_BITS-1:0] sel_sample;
  logic signed [SAMPLE_BITS-1:0] center;
  logic signed [SAMPLE_BITS:0]   pair [NUM_LANES-1];
  logic signed [sfir_pkg::WEIGHT_W-1:0] lane_weight [NUM_LANES];
  logic signed [SAMPLE_BITS-1:0] filt;

  assign ready3       = !v3 || !result_stall;
  assign ready2       = !v2 || ready3;
  assign s1_last      = !flush1 || (cnt1 == '0);
  assign sample_stall = v1 && !(ready2 && s1_last);
  assign in_xfer      = sample_valid && !sample_stall;
  assign t12          = v1 && ready2;
  assign result_valid = v3;

  assign len_c      = (int'(half_length) > EFF_MAX) ? sfir_pkg::LEN_W'(EFF_MAX) : half_length;
  assign last_index = row_width - sfir_pkg::ROW_W'(1);
  assign at_last    = (sample_index == last_index);
  assign past_len   = (sample_index >= {{(sfir_pkg::ROW_W-sfir_pkg::LEN_W){1'b0}}, len_c});
  assign past_2len  = (sample_index >= {{(sfir_pkg::ROW_W-sfir_pkg::LEN_W-1){1'b0}}, len_c, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= sfir_pkg::ROW_WIDTH_RST;
      half_length <= sfir_pkg::HALF_LENGTH_RST;
      for (int k = 0; k < sfir_pkg::NUM_WEIGHTS; k++) begin
        weight[k] <= '0;
      end
      weight[0] <= sfir_pkg::WEIGHT_0_RST;
    end else if (write_enable) begin
      case (reg_index)
        sfir_pkg::REG_ROW_WIDTH: begin
          row_width <= write_data;
        end
        sfir_pkg::REG_HALF_LENGTH: begin
          half_length <= write_data[sfir_pkg::LEN_W-1:0];
        end
        default: begin
          weight[W_IDX_W'(reg_index - sfir_pkg::REG_WEIGHT_0)] <= write_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        dl[k] <= '0;
      end
      sample_index <= '0;
    end else if (in_xfer) begin
      dl[0] <= sample;
      for (int k = 1; k < DEPTH; k++) begin
        dl[k] <= dl[k-1];
      end
      sample_index <= at_last ? '0 : sample_index + sfir_pkg::ROW_W'(1);
    end
  end

  // stage 1: hold a flush until each of its pass-through results has moved on
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_xfer) begin
      v1 <= at_last || past_len;
    end else if (t12) begin
      if (s1_last) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      flush1 <= at_last;
      filt1  <= past_2len;
      len1   <= len_c;
      cnt1   <= past_len ? len_c : sample_index[sfir_pkg::LEN_W-1:0];
    end else if (t12 && !s1_last) begin
      cnt1 <= cnt1 - sfir_pkg::LEN_W'(1);
    end
  end

  assign sel_sample = dl[IDX_W'(flush1 ? cnt1 : len1)];
  assign center     = dl[IDX_W'(len1)];

  genvar d;
  generate
    for (d = 1; d < NUM_LANES; d++) begin : g_pair
      assign pair[d-1] = (d <= int'(len1)) ?
                         (SAMPLE_BITS+1)'(dl[IDX_W'(int'(len1) - d)]) +
                         (SAMPLE_BITS+1)'(dl[IDX_W'(int'(len1) + d)]) : '0;
    end
    for (d = 0; d < NUM_LANES; d++) begin : g_weight
      assign lane_weight[d] = weight[d];
    end
  endgenerate

  sfir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_LANES   (NUM_LANES)
  ) u_mac (
    .clk    (clk),
    .load   (t12),
    .center (center),
    .pair   (pair),
    .weight (lane_weight),
    .filt   (filt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (t12) begin
      pass2 <= sel_sample;
      filt2 <= !flush1 && filt1;
      end2  <= flush1 && (cnt1 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      value   <= filt2 ? filt : pass2;
      row_end <= end2;
    end
  end

endmodule

>>> hw/rtl/sfir_checker.sv
`include "symmetric_fir_row_filter_unit_assert.svh"

module sfir_checker #(
  parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic signed [SAMPLE_BITS-1:0] value,
  input logic                          row_end
);

  // a waiting result keeps its payload
  `SFIR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(value) && $stable(row_end))

  // reset empties the pipeline and frees the sample side
  `SFIR_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !result_valid && !sample_stall)

  // stall only follows a transfer or an earlier stall
  `SFIR_ASSERT_NOW(a_stall_cause, clk, rst, sample_stall, $past(sample_valid && !sample_stall) || $past(sample_stall))

endmodule

bind symmetric_fir_row_filter_unit sfir_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sfir_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value        (value),
  .row_end      (row_end)
);
